>>> hw/rtl/stack_vm_instruction_executor_core_macros.svh
// Assertion macros shared by the executor RTL.
// SVM_ASSERT checks at every clock edge outside reset.
// SVM_ASSERT_ALWAYS checks at every clock edge, reset included.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVM_ASSERT(lbl, prop, msg)
`define SVM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/svm_pkg.sv
package svm_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int VAR_SLOTS     = 1024;
  localparam int PROGRAM_DEPTH = 1024;

  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int STK_CW = $clog2(STACK_DEPTH + 1);
  localparam int VAR_AW = $clog2(VAR_SLOTS);
  localparam int PC_W   = $clog2(PROGRAM_DEPTH);

  localparam int IN_W  = 112;
  localparam int OUT_W = 168;
  localparam int CFG_W = 8;

  typedef enum logic [4:0] {
    OP_PUSHI = 5'd0,  OP_PUSHV = 5'd1,  OP_POP   = 5'd2,  OP_PUSH  = 5'd3,
    OP_LOAD  = 5'd4,  OP_STORE = 5'd5,  OP_ADD   = 5'd6,  OP_SUB   = 5'd7,
    OP_SUBI  = 5'd8,  OP_MUL   = 5'd9,  OP_DIV   = 5'd10, OP_CMP   = 5'd11,
    OP_SETGT = 5'd12, OP_SETLT = 5'd13, OP_SETEQ = 5'd14, OP_SETNE = 5'd15,
    OP_SETGE = 5'd16, OP_SETLE = 5'd17, OP_AND   = 5'd18, OP_OR    = 5'd19,
    OP_NOT   = 5'd20, OP_JZ    = 5'd21, OP_JLE   = 5'd22, OP_JMP   = 5'd23,
    OP_ALLOC = 5'd24, OP_READ  = 5'd25, OP_EMIT  = 5'd26, OP_WAIT  = 5'd27,
    OP_HALT  = 5'd28, OP_NOP   = 5'd29
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0, ERR_OVF   = 3'd1, ERR_EMPTY = 3'd2, ERR_NOVAR = 3'd3,
    ERR_DIV0  = 3'd4, ERR_LABEL = 3'd5, ERR_SENS  = 3'd6, ERR_BADOP = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    CFG_WATER = 2'd0, CFG_TEMP = 2'd1, CFG_DOOR = 2'd2, CFG_WEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] KIND_R0 = 2'd0;
  localparam logic [1:0] KIND_R1 = 2'd1;

  localparam logic [2:0] SEN_WATER  = 3'd0;
  localparam logic [2:0] SEN_TEMP   = 3'd1;
  localparam logic [2:0] SEN_DOOR   = 3'd2;
  localparam logic [2:0] SEN_WEIGHT = 3'd3;

  // Last member sits in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [7:0]  actuator_id;
    logic        target_found;
    logic [9:0]  jump_target;
    logic [2:0]  sensor_select;
    logic [9:0]  var_slot;
    logic [31:0] imm_second;
    logic [31:0] imm_first;
    logic [1:0]  arg2_kind;
    logic [1:0]  arg1_kind;
    logic [4:0]  req_type;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [10:0] vars_in_use;
    logic [31:0] total_ticks;
    logic [31:0] reg_one;
    logic [31:0] reg_zero;
    logic [31:0] emit_value;
    logic [7:0]  emit_target;
    logic        emit_valid;
    logic [2:0]  error_code;
    logic        halted_now;
    logic [9:0]  next_pc;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic div_start;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic clr_last;
  } sts_t;

endpackage

>>> hw/rtl/svm_div.sv
module svm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        neg;
  logic [31:0] rsh;
  logic [32:0] diff;

  assign rsh      = {rem[30:0], quo[31]};
  assign diff     = {1'b0, rsh} - {1'b0, dvs};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rsh;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/svm_dp.sv
module svm_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  svm_pkg::cmd_t            cmd,
  output svm_pkg::sts_t            sts,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [svm_pkg::CFG_W-1:0] cfg_data,
  input  logic [svm_pkg::IN_W-1:0] in_data,
  output logic [svm_pkg::OUT_W-1:0] out_data
);

  localparam int STK_AW = svm_pkg::STK_AW;
  localparam int STK_CW = svm_pkg::STK_CW;
  localparam int VAR_AW = svm_pkg::VAR_AW;
  localparam int PC_W   = svm_pkg::PC_W;

  logic [6:0] sen_water;
  logic [7:0] sen_temp;
  logic       sen_door;
  logic [7:0] sen_weight;

  logic [31:0]       r0, r0_next;
  logic [31:0]       r1, r1_next;
  logic [STK_CW-1:0] cnt, cnt_next;
  logic [10:0]       tot, tot_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic              stopped, stopped_next;
  logic [31:0]       ticks, ticks_next;

  svm_pkg::in_item_t  item;
  svm_pkg::out_item_t out_q;

  logic [31:0] stk_mem [svm_pkg::STACK_DEPTH];
  logic [31:0] var_mem [svm_pkg::VAR_SLOTS];
  logic        pres_mem [svm_pkg::VAR_SLOTS];
  logic [31:0] stk_rd;
  logic [31:0] var_rd;
  logic        pres_rd;
  logic [VAR_AW-1:0] clr_idx;

  logic        stk_we, var_we, pres_set;
  logic [31:0] stk_wd, var_wd;
  svm_pkg::err_t fault;
  logic        emit, jump;
  logic        r0src, r1dst, r0r1, slot_ok, ovf;
  logic [31:0] popv, sens_v, st_v, prod, cmp_a, cmp_b;
  logic        div_done;
  logic [31:0] div_q;
  svm_pkg::in_item_t in_view;

  assign in_view = svm_pkg::in_item_t'(in_data);

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (r0),
    .divisor  (r1),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sen_water  <= 7'd50;
      sen_temp   <= 8'd20;
      sen_door   <= 1'b1;
      sen_weight <= 8'd5;
    end else if (cfg_we) begin
      case (svm_pkg::cfg_idx_t'(cfg_addr))
        svm_pkg::CFG_WATER:  sen_water  <= cfg_data[6:0];
        svm_pkg::CFG_TEMP:   sen_temp   <= cfg_data[7:0];
        svm_pkg::CFG_DOOR:   sen_door   <= cfg_data[0];
        svm_pkg::CFG_WEIGHT: sen_weight <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture the beat and issue all memory reads at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item    <= in_view;
      stk_rd  <= stk_mem[STK_AW'(cnt - STK_CW'(1))];
      var_rd  <= var_mem[in_view.var_slot[VAR_AW-1:0]];
      pres_rd <= pres_mem[in_view.var_slot[VAR_AW-1:0]];
    end
    if (cmd.commit && stk_we) stk_mem[cnt[STK_AW-1:0]] <= stk_wd;
    if (cmd.commit && var_we) var_mem[item.var_slot[VAR_AW-1:0]] <= var_wd;
    if (cmd.clr_en) pres_mem[clr_idx] <= 1'b0;
    else if (cmd.commit && pres_set) pres_mem[item.var_slot[VAR_AW-1:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clr_en) clr_idx <= clr_idx + VAR_AW'(1);
  end

  assign r0src   = (item.arg1_kind == svm_pkg::KIND_R0);
  assign r1dst   = (item.arg1_kind == svm_pkg::KIND_R1);
  assign r0r1    = r0src && (item.arg2_kind == svm_pkg::KIND_R1);
  assign slot_ok = ({22'd0, item.var_slot} < svm_pkg::VAR_SLOTS);
  assign ovf     = (cnt >= STK_CW'(svm_pkg::STACK_DEPTH));
  assign popv    = (cnt == '0) ? 32'd0 : stk_rd;
  assign prod    = r0 * r1;
  assign cmp_a   = r0src ? r0 : item.imm_first;
  assign cmp_b   = (item.arg2_kind == svm_pkg::KIND_R1) ? r1 : item.imm_second;
  assign st_v    = (item.arg2_kind == svm_pkg::KIND_R0) ? r0 :
                   (item.arg2_kind == svm_pkg::KIND_R1) ? r1 : item.imm_second;

  always_comb begin
    case (item.sensor_select)
      svm_pkg::SEN_WATER: sens_v = {25'd0, sen_water};
      svm_pkg::SEN_TEMP:  sens_v = {{24{sen_temp[7]}}, sen_temp};
      svm_pkg::SEN_DOOR:  sens_v = {31'd0, sen_door};
      default:            sens_v = {24'd0, sen_weight};
    endcase
  end

  assign sts.need_div = !stopped && (item.req_type == svm_pkg::OP_DIV) && r0r1 && (r1 != '0);
  assign sts.div_done = div_done;
  assign sts.clr_last = cmd.clr_en && (clr_idx == VAR_AW'(svm_pkg::VAR_SLOTS - 1));

  always_comb begin
    r0_next      = r0;
    r1_next      = r1;
    cnt_next     = cnt;
    tot_next     = tot;
    ticks_next   = ticks;
    stopped_next = stopped;
    pc_next      = pc;
    fault        = svm_pkg::ERR_NONE;
    emit         = 1'b0;
    jump         = 1'b0;
    stk_we       = 1'b0;
    stk_wd       = '0;
    var_we       = 1'b0;
    var_wd       = '0;
    pres_set     = 1'b0;
    if (!stopped) begin
      case (svm_pkg::op_t'(item.req_type))
        svm_pkg::OP_PUSHI: begin
          if (ovf) fault = svm_pkg::ERR_OVF;
          else begin
            stk_we = 1'b1; stk_wd = item.imm_first; cnt_next = cnt + STK_CW'(1);
          end
        end
        svm_pkg::OP_PUSHV: begin
          if (!slot_ok || !pres_rd) fault = svm_pkg::ERR_NOVAR;
          else if (ovf) fault = svm_pkg::ERR_OVF;
          else begin
            stk_we = 1'b1; stk_wd = var_rd; cnt_next = cnt + STK_CW'(1);
          end
        end
        svm_pkg::OP_POP: begin
          if (r0src || r1dst) begin
            if (cnt == '0) fault = svm_pkg::ERR_EMPTY;
            else cnt_next = cnt - STK_CW'(1);
            if (r0src) r0_next = popv;
            else r1_next = popv;
          end
        end
        svm_pkg::OP_PUSH: begin
          if (r0src || r1dst) begin
            if (ovf) fault = svm_pkg::ERR_OVF;
            else begin
              stk_we = 1'b1; stk_wd = r0src ? r0 : r1; cnt_next = cnt + STK_CW'(1);
            end
          end
        end
        svm_pkg::OP_LOAD: begin
          if (!slot_ok || !pres_rd) fault = svm_pkg::ERR_NOVAR;
          else if (r0src) r0_next = var_rd;
          else if (r1dst) r1_next = var_rd;
        end
        svm_pkg::OP_STORE: begin
          if (slot_ok) begin
            var_we = 1'b1; var_wd = st_v;
            if (!pres_rd) begin
              pres_set = 1'b1; tot_next = tot + 11'd1;
            end
          end
        end
        svm_pkg::OP_ADD:   if (r0r1) r0_next = r0 + r1;
        svm_pkg::OP_SUB:   if (r0r1) r0_next = r0 - r1;
        svm_pkg::OP_SUBI:  if (r0src) r0_next = r0 - item.imm_second;
        svm_pkg::OP_MUL:   if (r0r1) r0_next = prod;
        svm_pkg::OP_DIV: begin
          if (r0r1) begin
            if (r1 == '0) fault = svm_pkg::ERR_DIV0;
            else r0_next = div_q;
          end
        end
        svm_pkg::OP_CMP: begin
          if ($signed(cmp_b) < $signed(cmp_a)) r0_next = 32'd1;
          else if ($signed(cmp_a) < $signed(cmp_b)) r0_next = 32'hFFFF_FFFF;
          else r0_next = 32'd0;
        end
        svm_pkg::OP_SETGT: r0_next = {31'd0, ($signed(r0) > 0)};
        svm_pkg::OP_SETLT: r0_next = {31'd0, r0[31]};
        svm_pkg::OP_SETEQ: r0_next = {31'd0, (r0 == '0)};
        svm_pkg::OP_SETNE: r0_next = {31'd0, (r0 != '0)};
        svm_pkg::OP_SETGE: r0_next = {31'd0, !r0[31]};
        svm_pkg::OP_SETLE: r0_next = {31'd0, !($signed(r0) > 0)};
        svm_pkg::OP_AND:   r0_next = {31'd0, (r0 != '0) && (r1 != '0)};
        svm_pkg::OP_OR:    r0_next = {31'd0, (r0 != '0) || (r1 != '0)};
        svm_pkg::OP_NOT:   r0_next = {31'd0, (r0 == '0)};
        svm_pkg::OP_JZ, svm_pkg::OP_JLE, svm_pkg::OP_JMP: begin
          if ((item.req_type == svm_pkg::OP_JMP) ||
              ((item.req_type == svm_pkg::OP_JZ) && (r0 == '0)) ||
              ((item.req_type == svm_pkg::OP_JLE) && !($signed(r0) > 0))) begin
            if (!item.target_found) fault = svm_pkg::ERR_LABEL;
            else jump = 1'b1;
          end
        end
        svm_pkg::OP_ALLOC: begin
          if (slot_ok && !pres_rd) begin
            pres_set = 1'b1; var_we = 1'b1; var_wd = '0; tot_next = tot + 11'd1;
          end
        end
        svm_pkg::OP_READ: begin
          if (item.sensor_select > svm_pkg::SEN_WEIGHT) fault = svm_pkg::ERR_SENS;
          else if (r0src) r0_next = sens_v;
          else if (r1dst) r1_next = sens_v;
        end
        svm_pkg::OP_EMIT:  emit = 1'b1;
        svm_pkg::OP_WAIT:  ticks_next = ticks + r0;
        svm_pkg::OP_HALT:  stopped_next = 1'b1;
        svm_pkg::OP_NOP:   ;
        default:           fault = svm_pkg::ERR_BADOP;
      endcase
      if (fault != svm_pkg::ERR_NONE) stopped_next = 1'b1;
      if (!stopped_next) pc_next = jump ? item.jump_target[PC_W-1:0] : pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r0      <= '0;
      r1      <= '0;
      cnt     <= '0;
      tot     <= '0;
      pc      <= '0;
      stopped <= 1'b0;
      ticks   <= '0;
    end else if (cmd.commit) begin
      r0      <= r0_next;
      r1      <= r1_next;
      cnt     <= cnt_next;
      tot     <= tot_next;
      pc      <= pc_next;
      stopped <= stopped_next;
      ticks   <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_q.pad         <= '0;
      out_q.next_pc     <= 10'(pc_next);
      out_q.halted_now  <= stopped_next;
      out_q.error_code  <= fault;
      out_q.emit_valid  <= emit;
      out_q.emit_target <= emit ? item.actuator_id : 8'd0;
      out_q.emit_value  <= emit ? r0_next : 32'd0;
      out_q.reg_zero    <= r0_next;
      out_q.reg_one     <= r1_next;
      out_q.total_ticks <= ticks_next;
      out_q.vars_in_use <= tot_next;
    end
  end

  assign out_data = out_q;

endmodule

>>> hw/rtl/svm_ctrl.sv
`include "stack_vm_instruction_executor_core_macros.svh"

module svm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  svm_pkg::sts_t sts,
  output svm_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.clr_en    = (state == S_CLR);
    cmd.accept    = in_valid && in_ready;
    case (state)
      S_CLR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: if (cmd.accept) state_next = S_EXEC;
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV:  if (sts.div_done) state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `SVM_ASSERT(a_commit_free, cmd.commit |-> (!out_valid || out_ready), "commit over held beat")
  `SVM_ASSERT(a_commit_shows, cmd.commit |=> out_valid, "committed beat not shown")
  `SVM_ASSERT(a_one_at_a_time, cmd.accept |=> !in_ready, "second beat taken mid-item")
  `SVM_ASSERT(a_div_wait, cmd.div_start |=> !cmd.commit, "commit before quotient")

endmodule

>>> hw/rtl/stack_vm_instruction_executor_core.sv
// Channel   Dir  Width  Contents
// s_axis    in   112    one pre-decoded instruction per beat
// m_axis    out  168    machine state after that instruction
// cfg       in   8      sensor value writes, index 0..3
//
// An instruction passes two steps: accept (memory reads issued) and execute
// (state, stack and variable memories updated, result registered).
// An executing DIV also waits for the bit-serial divider.
// After reset a clearing pass over the variable valid bits runs;
// s_axis_tready stays low meanwhile, cfg writes are taken.
// A held result stalls execution; the next beat is taken only after the
// current one is committed to the output register.
module stack_vm_instruction_executor_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [svm_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // req_type[4:0], arg1_kind[6:5], arg2_kind[8:7], imm_first[40:9],
  // imm_second[72:41], var_slot[82:73], sensor_select[85:83],
  // jump_target[95:86], target_found[96], actuator_id[104:97], zero pad
  input  logic [svm_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // next_pc[9:0], halted_now[10], error_code[13:11], emit_valid[14],
  // emit_target[22:15], emit_value[54:23], reg_zero[86:55], reg_one[118:87],
  // total_ticks[150:119], vars_in_use[161:151], zero pad
  output logic [svm_pkg::OUT_W-1:0]  m_axis_tdata
);

  svm_pkg::cmd_t cmd;
  svm_pkg::sts_t sts;

  // Sequence each instruction.
  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold machine state, memories and the result register.
  svm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule
